FILE: sv/rbor_pkg.sv
// Shared types, constants and the CRC-32C byte step for the record batch offset rewriter.
package rbor_pkg;

  localparam int unsigned MAX_BUFFER_BYTES = 16777216;
  localparam int unsigned POS_W = $clog2(MAX_BUFFER_BYTES) + 1;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_BUFFER_BYTES);
  localparam logic [POS_W-1:0] OFF_LEN_FIRST = POS_W'(8);
  localparam logic [POS_W-1:0] OFF_LEN_LAST = POS_W'(11);
  localparam logic [POS_W-1:0] OFF_CRC_START = POS_W'(21);
  localparam logic [POS_W-1:0] OFF_DELTA_FIRST = POS_W'(23);
  localparam logic [POS_W-1:0] OFF_DELTA_LAST = POS_W'(26);

  localparam logic [31:0] MIN_LENGTH = 32'd45;
  localparam logic [32:0] HEADER_TAIL = 33'd11;
  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [23:0] COUNT_MAX = 24'hFF_FFFF;

  localparam logic KIND_PATCH = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               end_of_buffer;
    logic signed [63:0] first_offset;
  } rbor_item_t;

  typedef struct packed {
    logic               kind;
    logic [23:0]        batch_position;
    logic signed [63:0] new_base_offset;
    logic [31:0]        new_checksum;
    logic [23:0]        batches_patched;
    logic               stopped_early;
    logic               final_result;
  } rbor_result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: sv/rbor_parser.sv
// Batch header parser: position tracking, length and delta capture, CRC, patch and summary results.
module rbor_parser import rbor_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  rbor_item_t   item,
  output rbor_result_t res_a,
  output rbor_result_t res_b,
  output logic [1:0]   res_count
);

  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] bpos, bpos_next;
  logic [31:0]      len, len_next;
  logic [63:0]      running, running_next;
  logic [31:0]      delta, delta_next;
  logic [31:0]      crc, crc_next;
  logic [23:0]      cnt, cnt_next;
  logic             halted, halted_next;

  logic [POS_W-1:0] off;
  logic [63:0]      add;
  logic             patch;
  rbor_result_t     patch_res;
  rbor_result_t     sum_res;

  always_comb begin
    pos_next = pos;
    bpos_next = bpos;
    len_next = len;
    running_next = running;
    delta_next = delta;
    crc_next = crc;
    cnt_next = cnt;
    halted_next = halted;
    patch = 1'b0;
    add = 64'd1;
    off = pos - bpos;
    patch_res = '0;
    sum_res = '0;

    if (pos == '0) running_next = item.first_offset;
    if (pos >= MAX_POS) halted_next = 1'b1;

    if (!halted_next) begin
      if (off == '0) begin
        crc_next = CRC_INIT;
        len_next = '0;
        delta_next = '0;
      end
      if (off >= OFF_LEN_FIRST && off <= OFF_LEN_LAST) len_next = {len_next[23:0], item.data_byte};
      if (off >= OFF_DELTA_FIRST && off <= OFF_DELTA_LAST)
        delta_next = {delta_next[23:0], item.data_byte};
      if (off >= OFF_CRC_START) crc_next = crc_byte(crc_next, item.data_byte);

      if (off == OFF_LEN_LAST) begin
        // signed length below the minimum header size: give up on the buffer
        if (len_next[31] || len_next < MIN_LENGTH) halted_next = 1'b1;
      end else if (off > OFF_LEN_LAST && 33'(off) == {1'b0, len_next} + HEADER_TAIL) begin
        patch = 1'b1;
        patch_res.kind = KIND_PATCH;
        patch_res.batch_position = bpos[23:0];
        patch_res.new_base_offset = running_next;
        patch_res.new_checksum = ~crc_next;
        patch_res.final_result = !item.end_of_buffer;
        if (cnt_next != COUNT_MAX) cnt_next = cnt_next + 24'd1;
        add = delta_next[31] ? 64'd1 : (64'(delta_next) + 64'd1);
        running_next = running_next + add;
        bpos_next = pos + POS_W'(1);
      end
    end

    if (pos < MAX_POS) pos_next = pos + POS_W'(1);

    if (item.end_of_buffer) begin
      sum_res.kind = KIND_SUMMARY;
      sum_res.batches_patched = cnt_next;
      sum_res.stopped_early = halted_next || (pos_next != bpos_next);
      sum_res.final_result = 1'b1;
      // next beat starts a fresh buffer
      pos_next = '0;
      bpos_next = '0;
      len_next = '0;
      delta_next = '0;
      crc_next = CRC_INIT;
      cnt_next = '0;
      halted_next = 1'b0;
    end
  end

  always_comb begin
    res_a = patch ? patch_res : sum_res;
    res_b = sum_res;
    res_count = {1'b0, patch} + {1'b0, item.end_of_buffer};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      bpos <= '0;
      len <= '0;
      running <= '0;
      delta <= '0;
      crc <= CRC_INIT;
      cnt <= '0;
      halted <= 1'b0;
    end else if (step) begin
      pos <= pos_next;
      bpos <= bpos_next;
      len <= len_next;
      running <= running_next;
      delta <= delta_next;
      crc <= crc_next;
      cnt <= cnt_next;
      halted <= halted_next;
    end
  end

  a_bpos_le_pos: assert property (@(posedge clk) disable iff (rst) bpos <= pos)
    else $error("batch start beyond buffer position");

  a_eob_clears: assert property (@(posedge clk) disable iff (rst)
    step && item.end_of_buffer |=> pos == '0 && cnt == '0 && !halted)
    else $error("buffer state not cleared after end of buffer");

  a_halted_no_patch: assert property (@(posedge clk) disable iff (rst)
    halted && !(pos == '0) |-> !patch)
    else $error("patch issued while halted");

endmodule

FILE: sv/rbor_result_fifo.sv
// Small result queue: takes up to two results per cycle, hands out one per beat.
module rbor_result_fifo import rbor_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic [1:0]   push_count,
  input  rbor_result_t push_a,
  input  rbor_result_t push_b,
  output logic         room,
  output logic         out_valid,
  input  logic         out_ready,
  output rbor_result_t head
);

  rbor_result_t          mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  pop;

  assign out_valid = count != '0;
  assign pop = out_valid && out_ready;
  // room for two results regardless of this cycle's pop
  assign room = count <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) mem[wr_ptr] <= push_a;
    if (push_count == 2'd2) mem[wr_ptr + FIFO_PTR_W'(1)] <= push_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_W'(push_count);
      if (pop) rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      count <= count + FIFO_CNT_W'(push_count) - FIFO_CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push_count != 2'd0 |-> room)
    else $error("result queue overflow");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue count out of range");

endmodule

FILE: sv/record_batch_offset_rewriter.sv
// Top level of the record batch offset rewriter: input register, parser and result queue.
//
// Input channel (in_valid/in_ready) carries one buffer byte per beat with end_of_buffer
// marking the last byte and first_offset sampled on a buffer's first byte. Output channel
// (out_valid/out_ready) carries results: a batch patch (kind 0) when the last byte of a
// complete batch passes, and a summary (kind 1) on the end-of-buffer byte. A byte can
// produce up to two results; final_result marks the last one of that byte.
// Path: an accepted byte is held in the input register, then its results are written into
// the queue once it has room; the queue head is offered on the output channel.
// Throughput: one byte per cycle; the input register feeds the parser whenever the
// four-entry result queue has room for two results, so a byte that yields two results
// costs one extra output beat, absorbed by the queue.
// Reset clears buffer position, counters, CRC state and the queue; the first byte after
// reset starts a new buffer. When the receiver stalls, results collect in the queue and
// in_ready drops once the input register holds a byte and the queue holds three or more
// results; nothing is dropped.
// The host applies patches: new_base_offset big-endian at batch bytes 0..7 and
// new_checksum big-endian at bytes 17..20.
module record_batch_offset_rewriter import rbor_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               end_of_buffer,
  input  logic signed [63:0] first_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic [23:0]        batch_position,
  output logic signed [63:0] new_base_offset,
  output logic [31:0]        new_checksum,
  output logic [23:0]        batches_patched,
  output logic               stopped_early,
  output logic               final_result
);

  rbor_item_t   item;
  logic         item_valid;
  logic         step;
  logic         room;
  rbor_result_t res_a;
  rbor_result_t res_b;
  logic [1:0]   res_count;
  logic [1:0]   push_count;
  rbor_result_t head;

  assign step = item_valid && room;
  assign in_ready = !item_valid || step;
  assign push_count = step ? res_count : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.data_byte <= data_byte;
      item.end_of_buffer <= end_of_buffer;
      item.first_offset <= first_offset;
    end
  end

  rbor_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (item),
    .res_a     (res_a),
    .res_b     (res_b),
    .res_count (res_count)
  );

  rbor_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push_a     (res_a),
    .push_b     (res_b),
    .room       (room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .head       (head)
  );

  assign kind = head.kind;
  assign batch_position = head.batch_position;
  assign new_base_offset = head.new_base_offset;
  assign new_checksum = head.new_checksum;
  assign batches_patched = head.batches_patched;
  assign stopped_early = head.stopped_early;
  assign final_result = head.final_result;

endmodule
